### sv/fba_pkg.sv
// ----------------------------------------------------------------------------
// Fit block allocator package
// Shared widths, register indexes, fit mode codes and control structs.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int INDEX_W       = 4;
  localparam int AMOUNT_W      = 16;
  localparam int FAIL_W        = 16;
  localparam int BLOCK_COUNT_W = 5;
  localparam int FIT_MODE_W    = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 5;

  localparam logic [FAIL_W-1:0] FAIL_MAX = '1;
  localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

  localparam logic [CFG_INDEX_W-1:0] REG_FIT_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 2'd1;

  localparam logic [FIT_MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [FIT_MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [FIT_MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_load;
    logic accept_req;
    logic issue;
    logic finish;
  } fba_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
    logic rd_pending;
    logic out_free;
  } fba_stat_t;

endpackage

### sv/fba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/fba_ctrl.sv
// ----------------------------------------------------------------------------
// Fit block allocator controller
// Sequences load, table scan and result write-back for one request at a time.
// ----------------------------------------------------------------------------
module fba_ctrl import fba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      cmd,
  output logic      in_ready,
  input  fba_stat_t stat,
  output fba_ctl_t  ctl
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DONE
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl.accept_load = accept && (cmd == CMD_LOAD);
    ctl.accept_req  = accept && (cmd == CMD_REQUEST);
    ctl.issue       = (state == SCAN) && !stat.scan_end;
    ctl.finish      = (state == DONE) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (ctl.accept_load) begin
            state <= DONE;
          end else if (ctl.accept_req) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          // The last read is still in flight after the final issue, until rd_pending clears.
          if (stat.scan_end && !stat.rd_pending) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (stat.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### sv/fba_dpath.sv
// ----------------------------------------------------------------------------
// Fit block allocator datapath
// Configuration, size table, scan compare, miss counter and result register.
// ----------------------------------------------------------------------------
module fba_dpath import fba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic [INDEX_W-1:0]       load_index,
  input  logic [AMOUNT_W-1:0]      amount,
  input  logic                     last_request,
  input  fba_ctl_t                 ctl,
  output fba_stat_t                stat,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     granted,
  output logic [INDEX_W-1:0]       chosen_block,
  output logic [AMOUNT_W-1:0]      space_left,
  output logic [FAIL_W-1:0]        failed_count
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W  = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
  localparam int PICK_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
  localparam int BC_W   = (CNT_W > BLOCK_COUNT_W) ? CNT_W : BLOCK_COUNT_W;

  logic [FIT_MODE_W-1:0]    fit_mode;
  logic [BLOCK_COUNT_W-1:0] block_count;

  logic [AMOUNT_W-1:0]  amount_q;
  logic                 last_q;
  logic                 is_req;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     scan_idx;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_size;
  logic [FAIL_W-1:0]    miss;

  logic [BC_W-1:0]      bc_w;
  logic [BC_W-1:0]      lim_w;
  logic [PICK_W-1:0]    ld_w;
  logic                 ld_in_range;
  logic [CMP_W-1:0]     in_amt_w;
  logic [CMP_W-1:0]     amt_w;
  logic [CMP_W-1:0]     rd_w;
  logic [CMP_W-1:0]     best_w;
  logic [CMP_W-1:0]     diff_w;
  logic [SIZE_BITS-1:0] diff_s;
  logic [CMP_W-1:0]     space_w;
  logic [PICK_W-1:0]    pick_w;
  logic                 fits;
  logic                 take;
  logic [FAIL_W-1:0]    miss_inc;
  logic [FAIL_W-1:0]    miss_new;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;

  // Entries beyond the table size clamp to the full table.
  assign bc_w  = BC_W'(block_count);
  assign lim_w = (bc_w > BC_W'(MAX_BLOCKS)) ? BC_W'(MAX_BLOCKS) : bc_w;

  assign ld_w        = PICK_W'(load_index);
  assign ld_in_range = (32'(load_index) < MAX_BLOCKS);
  assign in_amt_w    = CMP_W'(amount);

  assign amt_w  = CMP_W'(amount_q);
  assign rd_w   = CMP_W'(ram_rdata);
  assign best_w = CMP_W'(best_size);
  assign fits   = (rd_w >= amt_w);

  always_comb begin
    take = 1'b0;
    if (rd_valid && fits) begin
      if (!found) begin
        take = 1'b1;
      end else if ((fit_mode == MODE_BEST) && (rd_w < best_w)) begin
        take = 1'b1;
      end else if ((fit_mode == MODE_WORST) && (rd_w > best_w)) begin
        take = 1'b1;
      end
    end
  end

  assign diff_w  = best_w - amt_w;
  assign diff_s  = diff_w[SIZE_BITS-1:0];
  assign space_w = CMP_W'(diff_s);
  assign pick_w  = PICK_W'(best_idx);

  assign miss_inc = (miss < FAIL_MAX) ? miss + FAIL_W'(1) : miss;
  assign miss_new = (is_req && !found) ? miss_inc : miss;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = diff_s;
    if (ctl.accept_load) begin
      ram_we    = ld_in_range;
      ram_waddr = ld_w[IDX_W-1:0];
      ram_wdata = in_amt_w[SIZE_BITS-1:0];
    end else if (ctl.finish) begin
      ram_we = is_req && found;
    end
  end

  fba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.scan_end   = (scan_idx >= limit);
    stat.rd_pending = rd_valid;
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode    <= MODE_FIRST;
      block_count <= BLOCK_COUNT_RST;
      miss        <= '0;
      rd_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_FIT_MODE) begin
          fit_mode <= cfg_data[FIT_MODE_W-1:0];
        end else if (cfg_index == REG_BLOCK_COUNT) begin
          block_count <= cfg_data[BLOCK_COUNT_W-1:0];
        end
      end

      rd_valid <= ctl.issue;

      if (ctl.finish) begin
        out_valid <= 1'b1;
        if (is_req && last_q) begin
          miss <= '0;
        end else begin
          miss <= miss_new;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept_load || ctl.accept_req) begin
      amount_q <= amount;
      last_q   <= last_request;
      is_req   <= ctl.accept_req;
      limit    <= lim_w[CNT_W-1:0];
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (ctl.issue) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end

    rd_idx <= scan_idx[IDX_W-1:0];

    if (take) begin
      found     <= 1'b1;
      best_idx  <= rd_idx;
      best_size <= ram_rdata;
    end

    if (ctl.finish) begin
      granted      <= is_req && found;
      chosen_block <= (is_req && found) ? pick_w[INDEX_W-1:0] : '0;
      space_left   <= (is_req && found) ? space_w[AMOUNT_W-1:0] : '0;
      failed_count <= miss_new;
    end
  end

endmodule

### sv/fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// Fit block allocator
// Table of free block sizes with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries either a load, which writes
//   one size into the table, or an allocation request. Every item yields one
//   result on the output channel (out_valid/out_ready).
//   The configuration channel (cfg_valid/cfg_ready) is always ready; index 0
//   selects the fit mode and index 1 the number of entries searched. Write
//   it only while no item is in progress.
//   A load writes its size into the table on acceptance and then returns its
//   result. A request reads the table through the single read port of the
//   size RAM, one entry a cycle, over the configured number of entries, and
//   then writes back its result. Items are handled one at a time: the next
//   item is accepted only once the result of the last one is registered.
//   Results sit in an output register: the next item is accepted while a
//   result waits, and only the final write-back of that next item waits for
//   the receiver. Reset clears the miss counter and the configuration
//   (first fit, 16 entries); table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module fit_block_allocator_unit import fba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic [INDEX_W-1:0]     load_index,
  input  logic [AMOUNT_W-1:0]    amount,
  input  logic                   last_request,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   granted,
  output logic [INDEX_W-1:0]     chosen_block,
  output logic [AMOUNT_W-1:0]    space_left,
  output logic [FAIL_W-1:0]      failed_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  fba_ctl_t  ctl;
  fba_stat_t stat;

  assign cfg_ready = 1'b1;

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  fba_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .load_index   (load_index),
    .amount       (amount),
    .last_request (last_request),
    .ctl          (ctl),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted      (granted),
    .chosen_block (chosen_block),
    .space_left   (space_left),
    .failed_count (failed_count)
  );

endmodule
